FILE: hw/rtl/tprf_pkg.sv
// Shared types and constants for the tape record framer.
// No dependencies; used by tprf_core, tprf_emit and tape_record_framer_unit.
`default_nettype none

package tprf_pkg;

  localparam int unsigned HEADER_BYTES = 14;
  localparam int unsigned LEN_OFFSET   = 10;
  localparam int unsigned SYNC_MAX     = 62;

  localparam logic [5:0] SYNC_COUNT_RESET  = 6'd31;
  localparam logic [7:0] SYNC_VALUE_RESET  = 8'hE6;
  localparam logic [7:0] START_VALUE_RESET = 8'h01;

  localparam logic [7:0] TYPE_END_A = 8'd2;
  localparam logic [7:0] TYPE_END_B = 8'd3;

  // configuration register indexes
  localparam logic [1:0] REG_SYNC_COUNT  = 2'd0;
  localparam logic [1:0] REG_SYNC_VALUE  = 2'd1;
  localparam logic [1:0] REG_START_VALUE = 2'd2;

  typedef enum logic [2:0] {
    KIND_SYNC  = 3'd0,
    KIND_START = 3'd1,
    KIND_HDR   = 3'd2,
    KIND_HSUM  = 3'd3,
    KIND_DATA  = 3'd4,
    KIND_DSUM  = 3'd5
  } kind_t;

  // Everything the emitter needs to send the words caused by one image word.
  typedef struct packed {
    logic       has_pre;    // sync run and start word come first
    logic [5:0] sync_cnt;   // already limited to SYNC_MAX
    logic [7:0] sync_val;
    logic [7:0] start_val;
    logic [7:0] main_byte;
    kind_t      main_kind;
    logic       has_sum;
    logic [7:0] sum_byte;
    kind_t      sum_kind;
    logic       sum_end;    // header sum of an end record
  } plan_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tprf_core.sv
// Input register, record tracking and configuration for the tape record framer.
// Depends on tprf_pkg; feeds one plan per image word to tprf_emit.
`default_nettype none

module tprf_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           image_valid,
  output logic                image_stall,
  input  wire logic [7:0]     image_byte,
  input  wire logic           cfg_we,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [7:0]     cfg_data,
  output logic                push,
  output tprf_pkg::plan_t     plan,
  input  wire logic           emit_ready
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1,
    PH_ENDED  = 2'd2
  } phase_t;

  phase_t     phase;
  logic [8:0] byte_index;
  logic [7:0] running_sum;
  logic [8:0] data_length;
  logic [5:0] sync_count;
  logic [7:0] sync_value;
  logic [7:0] start_value;
  logic       word_valid;
  logic [7:0] word_byte;

  logic       consume;
  logic [8:0] index_inc;
  logic [7:0] sum_inc;
  logic       part_done;
  logic       is_end;

  assign consume     = word_valid && (phase == PH_ENDED || emit_ready);
  assign push        = consume && phase != PH_ENDED;
  assign image_stall = word_valid && !consume;

  assign index_inc = byte_index + 9'd1;
  assign sum_inc   = running_sum + word_byte;
  assign is_end    = word_byte == tprf_pkg::TYPE_END_A || word_byte == tprf_pkg::TYPE_END_B;

  always_comb begin
    if (phase == PH_HEADER) begin
      part_done = index_inc == 9'(tprf_pkg::HEADER_BYTES);
    end else begin
      part_done = index_inc >= data_length;
    end
  end

  always_comb begin
    plan.has_pre   = phase == PH_HEADER && byte_index == 9'd0;
    plan.sync_cnt  = (sync_count > 6'(tprf_pkg::SYNC_MAX)) ? 6'(tprf_pkg::SYNC_MAX)
                                                           : sync_count;
    plan.sync_val  = sync_value;
    plan.start_val = start_value;
    plan.main_byte = word_byte;
    plan.main_kind = (phase == PH_HEADER) ? tprf_pkg::KIND_HDR : tprf_pkg::KIND_DATA;
    plan.has_sum   = part_done;
    plan.sum_byte  = 8'd0 - sum_inc;
    plan.sum_kind  = (phase == PH_HEADER) ? tprf_pkg::KIND_HSUM : tprf_pkg::KIND_DSUM;
    plan.sum_end   = phase == PH_HEADER && is_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid  <= 1'b0;
      phase       <= PH_HEADER;
      byte_index  <= 9'd0;
      running_sum <= 8'd0;
      data_length <= 9'd0;
      sync_count  <= tprf_pkg::SYNC_COUNT_RESET;
      sync_value  <= tprf_pkg::SYNC_VALUE_RESET;
      start_value <= tprf_pkg::START_VALUE_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tprf_pkg::REG_SYNC_COUNT:  sync_count  <= cfg_data[5:0];
          tprf_pkg::REG_SYNC_VALUE:  sync_value  <= cfg_data;
          tprf_pkg::REG_START_VALUE: start_value <= cfg_data;
          default: ;
        endcase
      end
      if (image_valid && !image_stall) begin
        word_valid <= 1'b1;
      end else if (consume) begin
        word_valid <= 1'b0;
      end
      if (push) begin
        if (phase == PH_HEADER && byte_index == 9'(tprf_pkg::LEN_OFFSET)) begin
          data_length <= (word_byte == 8'd0) ? 9'd256 : {1'b0, word_byte};
        end
        if (part_done) begin
          byte_index  <= 9'd0;
          running_sum <= 8'd0;
          if (phase == PH_HEADER) begin
            phase <= is_end ? PH_ENDED : PH_DATA;
          end else begin
            phase <= PH_HEADER;
          end
        end else begin
          byte_index  <= index_inc;
          running_sum <= sum_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (image_valid && !image_stall) begin
      word_byte <= image_byte;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tprf_emit.sv
// Output sequencer: sends the sync run, start, main and checksum words of one plan.
// Depends on tprf_pkg; takes plans from tprf_core.
`default_nettype none

module tprf_emit (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire tprf_pkg::plan_t plan,
  output logic                emit_ready,
  output logic                frame_valid,
  input  wire logic           frame_stall,
  output logic [7:0]          frame_byte,
  output logic [2:0]          byte_kind,
  output logic                run_last,
  output logic                tape_end
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_SYNC  = 3'd1,
    ST_START = 3'd2,
    ST_MAIN  = 3'd3,
    ST_SUM   = 3'd4
  } state_t;

  state_t          state;
  tprf_pkg::plan_t cur;
  logic [5:0]      remaining;
  logic            taken;

  assign frame_valid = state != ST_IDLE;
  assign taken       = frame_valid && !frame_stall;
  assign emit_ready  = state == ST_IDLE || (taken && run_last);

  always_comb begin
    frame_byte = cur.main_byte;
    byte_kind  = cur.main_kind;
    run_last   = 1'b0;
    tape_end   = 1'b0;
    unique case (state)
      ST_IDLE: ;
      ST_SYNC: begin
        frame_byte = cur.sync_val;
        byte_kind  = tprf_pkg::KIND_SYNC;
      end
      ST_START: begin
        frame_byte = cur.start_val;
        byte_kind  = tprf_pkg::KIND_START;
      end
      ST_MAIN: begin
        run_last = !cur.has_sum;
      end
      ST_SUM: begin
        frame_byte = cur.sum_byte;
        byte_kind  = cur.sum_kind;
        run_last   = 1'b1;
        tape_end   = cur.sum_end;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      remaining <= 6'd0;
    end else if (push) begin
      remaining <= plan.sync_cnt;
      if (!plan.has_pre) begin
        state <= ST_MAIN;
      end else if (plan.sync_cnt != 6'd0) begin
        state <= ST_SYNC;
      end else begin
        state <= ST_START;
      end
    end else if (taken) begin
      unique case (state)
        ST_SYNC: begin
          remaining <= remaining - 6'd1;
          if (remaining == 6'd1) begin
            state <= ST_START;
          end
        end
        ST_START: state <= ST_MAIN;
        ST_MAIN:  state <= cur.has_sum ? ST_SUM : ST_IDLE;
        ST_SUM:   state <= ST_IDLE;
        default:  state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cur <= plan;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tape_record_framer_unit.sv
// Top level of the tape record framer: input register and record tracking
// (tprf_core) feeding the output word sequencer (tprf_emit). Uses tprf_pkg.
`default_nettype none

// Frames a tape image record stream into cassette words. Each image word
// yields one or more frame words: the first header word of a record brings
// sync_count sync words (63 counts as 62) and a start word ahead of it, the
// last header word and the last data word bring their two's-complement
// checksum after them, and every other word passes through alone. After an
// end record (type 2 or 3) image words are still taken but give nothing.
// Rate: one image word per cycle while each causes a single frame word and
// frame_stall is low; a word causing more frame words holds the output
// until all are sent. The figure is set by the output sequencer, which
// sends one frame word per cycle while frame_stall is low. The input register
// takes the next image word while the sequencer is still busy, so the image
// side stalls only when both are full. The user must write configuration
// through cfg_we/cfg_index/cfg_data only while idle; the block itself does
// not enforce it. An index beyond the three registers is ignored.

module tape_record_framer_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  // image words
  input  wire logic       image_valid,
  output logic            image_stall,
  input  wire logic [7:0] image_byte,
  // frame words
  output logic            frame_valid,
  input  wire logic       frame_stall,
  output logic [7:0]      frame_byte,
  output logic [2:0]      byte_kind,
  output logic            run_last,
  output logic            tape_end,
  // configuration: 0 sync_count, 1 sync_value, 2 start_value
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  // plan handed from the tracker to the sequencer when it can take one
  logic            push;
  logic            emit_ready;
  tprf_pkg::plan_t plan;

  tprf_core u_core (
    .clk         (clk),
    .rst         (rst),
    .image_valid (image_valid),
    .image_stall (image_stall),
    .image_byte  (image_byte),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push),
    .plan        (plan),
    .emit_ready  (emit_ready)
  );

  // sequencer: sync run, start, main word, checksum, one per unstalled cycle
  tprf_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .plan        (plan),
    .emit_ready  (emit_ready),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame_byte  (frame_byte),
    .byte_kind   (byte_kind),
    .run_last    (run_last),
    .tape_end    (tape_end)
  );

endmodule

`default_nettype wire
